// ===== hw/rtl/takf_pkg.sv =====
package takf_pkg;

  localparam int unsigned QW = 32;

  localparam logic [4:0] OP_NOP     = 5'd0;
  localparam logic [4:0] OP_MEAS    = 5'd1;
  localparam logic [4:0] OP_RATE    = 5'd2;
  localparam logic [4:0] OP_RMB     = 5'd3;
  localparam logic [4:0] OP_ANG_P   = 5'd4;
  localparam logic [4:0] OP_SLOPE0  = 5'd5;
  localparam logic [4:0] OP_P00_P   = 5'd6;
  localparam logic [4:0] OP_SLOPE1  = 5'd7;
  localparam logic [4:0] OP_P01_P   = 5'd8;
  localparam logic [4:0] OP_P10_P   = 5'd9;
  localparam logic [4:0] OP_P11_P   = 5'd10;
  localparam logic [4:0] OP_ERR     = 5'd11;
  localparam logic [4:0] OP_DIV0    = 5'd12;
  localparam logic [4:0] OP_DIV1    = 5'd13;
  localparam logic [4:0] OP_P10_C   = 5'd14;
  localparam logic [4:0] OP_P11_C   = 5'd15;
  localparam logic [4:0] OP_P00_C   = 5'd16;
  localparam logic [4:0] OP_P01_C   = 5'd17;
  localparam logic [4:0] OP_ANG_C   = 5'd18;
  localparam logic [4:0] OP_BIAS_C  = 5'd19;
  localparam logic [4:0] OP_OUT     = 5'd20;

  localparam logic [2:0] REG_QA = 3'd0;
  localparam logic [2:0] REG_QB = 3'd1;
  localparam logic [2:0] REG_RM = 3'd2;
  localparam logic [2:0] REG_DT = 3'd3;
  localparam logic [2:0] REG_AO = 3'd4;
  localparam logic [2:0] REG_GO = 3'd5;
  localparam logic [2:0] REG_AG = 3'd6;
  localparam logic [2:0] REG_GG = 3'd7;

  typedef struct packed {
    logic       load;
    logic       op_go;
    logic [4:0] op;
  } takf_cmd_t;

  typedef struct packed {
    logic op_done;
  } takf_stat_t;

  function automatic logic [31:0] sat32(input logic signed [95:0] x, output logic c);
    if (x > 96'sd2147483647) begin
      c = 1'b1;
      sat32 = 32'h7fffffff;
    end else if (x < -96'sd2147483648) begin
      c = 1'b1;
      sat32 = 32'h80000000;
    end else begin
      c = 1'b0;
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/takf_if.sv =====
interface takf_in_if #(parameter int SW = 16);
  logic valid;
  logic ready;
  logic signed [SW-1:0] accel_sample;
  logic signed [SW-1:0] gyro_sample;
  modport source (output valid, accel_sample, gyro_sample, input ready);
  modport sink (input valid, accel_sample, gyro_sample, output ready);
endinterface

interface takf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] fused_angle;
  logic signed [31:0] corrected_rate;
  logic saturated;
  modport source (output valid, fused_angle, corrected_rate, saturated, input ready);
  modport sink (input valid, fused_angle, corrected_rate, saturated, output ready);
endinterface

// ===== hw/rtl/takf_ctrl.sv =====
module takf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output takf_pkg::takf_cmd_t    cmd,
  input  takf_pkg::takf_stat_t   stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [4:0] op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= takf_pkg::OP_NOP;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.op = op;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          op_next = takf_pkg::OP_MEAS;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.op_go = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.op_done) begin
          if (op == takf_pkg::OP_OUT) begin
            state_next = S_OUT;
          end else begin
            op_next = op + 5'd1;
            state_next = S_ISSUE;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/takf_dp.sv =====
module takf_dp #(
  parameter int FRAC_BITS = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_sample,
  input  takf_pkg::takf_cmd_t           cmd,
  output takf_pkg::takf_stat_t          stat,
  output logic [31:0]                   fused_angle,
  output logic [31:0]                   corrected_rate,
  output logic                          saturated
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [95:0] HALF = 96'sd1 <<< (FRAC_BITS - 1);
  localparam int DBITS = 64;

  logic [31:0] qa, qb, rm, dt, ag, gg;
  logic signed [15:0] ao, go;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, rate, rmb, slope, err, k0, k1;
  logic signed [SAMPLE_WIDTH-1:0] as_r, gs_r;
  logic clip;

  logic [1:0] mph;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;

  logic [6:0] dcnt;
  logic [DBITS-1:0] dquo;
  logic [DBITS:0] drem, drem_mag;
  logic [33:0] dden;
  logic dneg, dzero;
  logic signed [31:0] dnum;

  logic signed [95:0] wide;
  logic signed [95:0] wres;
  logic [31:0] sres;
  logic sc;
  logic run;

  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= 32'd16777;
      qb <= 32'd50332;
      rm <= 32'd8388608;
      dt <= 32'd167772;
      ao <= 16'sd220;
      go <= 16'sd18;
      ag <= 32'd70442;
      gg <= 32'd1023001;
    end else if (cfg_we) begin
      case (cfg_index)
        takf_pkg::REG_QA: qa <= cfg_data;
        takf_pkg::REG_QB: qb <= cfg_data;
        takf_pkg::REG_RM: rm <= cfg_data;
        takf_pkg::REG_DT: dt <= cfg_data;
        takf_pkg::REG_AO: ao <= cfg_data[15:0];
        takf_pkg::REG_GO: go <= cfg_data[15:0];
        takf_pkg::REG_AG: ag <= cfg_data;
        takf_pkg::REG_GG: gg <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [33:0] fa, fb;
  logic use_mul, use_div, umul_mode;
  always_comb begin
    fa = '0;
    fb = '0;
    use_mul = 1'b1;
    use_div = 1'b0;
    umul_mode = 1'b0;
    case (cmd.op)
      takf_pkg::OP_MEAS: begin
        fa = 34'(as_r) + 34'(ao);
        fb = $signed({2'b0, ag});
      end
      takf_pkg::OP_RATE: begin
        fa = 34'(gs_r) + 34'(go);
        fb = $signed({2'b0, gg});
      end
      takf_pkg::OP_ANG_P: begin fa = 34'(rmb); fb = $signed({2'b0, dt}); end
      takf_pkg::OP_P00_P, takf_pkg::OP_P01_P, takf_pkg::OP_P10_P: begin
        fa = $signed({2'b0, dt});
        fb = 34'(slope);
      end
      takf_pkg::OP_P11_P: begin
        fa = $signed({2'b0, qb});
        fb = $signed({2'b0, dt});
        umul_mode = 1'b1;
      end
      takf_pkg::OP_P00_C, takf_pkg::OP_P01_C: begin
        fa = 34'(k0);
        fb = (cmd.op == takf_pkg::OP_P00_C) ? 34'(p00) : 34'(p01);
      end
      takf_pkg::OP_P10_C, takf_pkg::OP_P11_C: begin
        fa = 34'(k1);
        fb = (cmd.op == takf_pkg::OP_P10_C) ? 34'(p00) : 34'(p01);
      end
      takf_pkg::OP_ANG_C: begin fa = 34'(k0); fb = 34'(err); end
      takf_pkg::OP_BIAS_C: begin fa = 34'(k1); fb = 34'(err); end
      takf_pkg::OP_DIV0, takf_pkg::OP_DIV1: begin use_mul = 1'b0; use_div = 1'b1; end
      default: use_mul = 1'b0;
    endcase
  end

  logic signed [95:0] rnd;
  always_comb begin
    rnd = (96'(mprod) + HALF) >>> FRAC_BITS;
    wres = '0;
    case (cmd.op)
      takf_pkg::OP_MEAS, takf_pkg::OP_RATE: wres = 96'(mprod);
      takf_pkg::OP_RMB: wres = 96'(rate) - 96'(bias);
      takf_pkg::OP_SLOPE0: wres = 96'($signed({1'b0, qa})) - 96'(p01) - 96'(p10);
      takf_pkg::OP_SLOPE1: wres = -96'(p11);
      takf_pkg::OP_ERR: wres = 96'(meas) - 96'(ang);
      takf_pkg::OP_OUT: wres = 96'(rate) - 96'(bias);
      default: wres = rnd;
    endcase
  end

  logic [95:0] umul_p;
  logic [31:0] ures;
  logic uc;
  always_comb begin
    umul_p = 96'(mprod[63:0]);
    ures = takf_pkg::sat32($signed((umul_p >> FRAC_BITS) + 96'(umul_p[FRAC_BITS-1])), uc);
  end

  always_comb begin
    sres = takf_pkg::sat32(wres, sc);
    wide = umul_mode ? 96'($signed(ures)) : 96'($signed(sres));
  end

  logic signed [31:0] sum_src;
  logic signed [31:0] acc;
  logic sub;
  always_comb begin
    sum_src = '0;
    sub = 1'b0;
    case (cmd.op)
      takf_pkg::OP_ANG_P, takf_pkg::OP_ANG_C: sum_src = ang;
      takf_pkg::OP_P00_P: sum_src = p00;
      takf_pkg::OP_P01_P: sum_src = p01;
      takf_pkg::OP_P10_P: sum_src = p10;
      takf_pkg::OP_P11_P: sum_src = p11;
      takf_pkg::OP_P00_C: begin sum_src = p00; sub = 1'b1; end
      takf_pkg::OP_P01_C: begin sum_src = p01; sub = 1'b1; end
      takf_pkg::OP_P10_C: begin sum_src = p10; sub = 1'b1; end
      takf_pkg::OP_P11_C: begin sum_src = p11; sub = 1'b1; end
      takf_pkg::OP_BIAS_C: sum_src = bias;
      default: sum_src = '0;
    endcase
  end

  logic [31:0] acc_res;
  logic ac;
  always_comb begin
    acc_res = takf_pkg::sat32(sub ? 96'(sum_src) - wide : 96'(sum_src) + wide, ac);
    acc = $signed(acc_res);
  end

  logic signed [64:0] e_full;
  logic [63:0] num_mag;
  logic [32:0] den_mag;
  logic [31:0] qsat;
  logic qc;
  logic signed [95:0] qsig;
  always_comb begin
    e_full = 65'($signed({1'b0, rm})) + 65'(p00);
    num_mag = dnum[31] ? 64'(-64'(dnum)) << FRAC_BITS : 64'(dnum) << FRAC_BITS;
    den_mag = e_full[64] ? 33'(-e_full) : 33'(e_full);
    qsig = dneg ? -96'($signed({1'b0, dquo})) : 96'($signed({1'b0, dquo}));
    qsat = takf_pkg::sat32(qsig, qc);
  end

  always_comb begin
    drem_mag = {drem[DBITS-1:0], dquo[DBITS-1]};
  end

  logic op_end;
  always_comb begin
    if (use_div) op_end = run && !cmd.op_go && (dcnt == 7'(DBITS));
    else op_end = run && !cmd.op_go && (!use_mul || mph != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang <= '0;
      bias <= '0;
      p00 <= 32'(ONE);
      p01 <= '0;
      p10 <= '0;
      p11 <= 32'(ONE);
      mph <= '0;
      run <= 1'b0;
      stat <= '0;
      clip <= 1'b0;
    end else begin
      stat.op_done <= op_end;
      if (cmd.load) begin
        as_r <= accel_sample;
        gs_r <= gyro_sample;
        clip <= 1'b0;
      end
      if (cmd.op_go) begin
        run <= 1'b1;
        mph <= '0;
        if (use_div) begin
          dcnt <= 7'd0;
          dnum <= (cmd.op == takf_pkg::OP_DIV0) ? p00 : p10;
          dneg <= ((cmd.op == takf_pkg::OP_DIV0) ? p00[31] : p10[31]) ^ e_full[64];
          dzero <= (e_full == '0);
          dden <= 34'(den_mag);
          drem <= '0;
        end
      end else if (run) begin
        if (use_mul && mph == 2'd0) begin
          mprod <= fa * fb;
          mph <= 2'd1;
        end else if (use_div) begin
          if (dcnt == 7'd0 && mph == 2'd0) begin
            dquo <= num_mag;
            mph <= 2'd1;
          end else if (dcnt < 7'(DBITS)) begin
            if (drem_mag >= 65'(dden)) begin
              drem <= drem_mag - 65'(dden);
              dquo <= {dquo[DBITS-2:0], 1'b1};
            end else begin
              drem <= drem_mag;
              dquo <= {dquo[DBITS-2:0], 1'b0};
            end
            dcnt <= dcnt + 7'd1;
          end else begin
            run <= 1'b0;
            if (cmd.op == takf_pkg::OP_DIV0) k0 <= dzero ? '0 : $signed(qsat);
            else k1 <= dzero ? '0 : $signed(qsat);
            if (!dzero) clip <= clip | qc;
          end
        end else begin
          run <= 1'b0;
          case (cmd.op)
            takf_pkg::OP_MEAS: begin meas <= $signed(sres); clip <= clip | sc; end
            takf_pkg::OP_RATE: begin rate <= $signed(sres); clip <= clip | sc; end
            takf_pkg::OP_RMB: begin rmb <= $signed(sres); clip <= clip | sc; end
            takf_pkg::OP_SLOPE0, takf_pkg::OP_SLOPE1: begin
              slope <= $signed(sres);
              clip <= clip | sc;
            end
            takf_pkg::OP_ERR: begin err <= $signed(sres); clip <= clip | sc; end
            takf_pkg::OP_OUT: begin rate <= $signed(sres); clip <= clip | sc; end
            takf_pkg::OP_P11_P: begin
              p11 <= acc;
              clip <= clip | uc | ac;
            end
            default: begin
              clip <= clip | sc | ac;
              case (cmd.op)
                takf_pkg::OP_ANG_P, takf_pkg::OP_ANG_C: ang <= acc;
                takf_pkg::OP_P00_P, takf_pkg::OP_P00_C: p00 <= acc;
                takf_pkg::OP_P01_P, takf_pkg::OP_P01_C: p01 <= acc;
                takf_pkg::OP_P10_P, takf_pkg::OP_P10_C: p10 <= acc;
                takf_pkg::OP_P11_C: p11 <= acc;
                takf_pkg::OP_BIAS_C: bias <= acc;
                default: ;
              endcase
            end
          endcase
        end
      end
    end
  end

  assign fused_angle = ang;
  assign corrected_rate = rate;
  assign saturated = clip;

endmodule

// ===== hw/rtl/tilt_angle_kalman_fusion.sv =====
// Channel   Direction  Payload
// in_ch     sink       accel_sample, gyro_sample
// out_ch    source     fused_angle, corrected_rate, saturated
// Each item is accepted in the idle state, then 20 datapath steps run one at a time
// (multiply steps, add steps and the two 64-step restoring divides), then the item
// waits in the output state until it is taken. Both divides share one radix-2 divider.
// Reset is synchronous and restores the registers, the state and the identity covariance.
// The input is not taken again until the result item has left.
module tilt_angle_kalman_fusion #(
  parameter int FRAC_BITS = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  takf_in_if.sink     in_ch,
  takf_out_if.source  out_ch
);

  takf_pkg::takf_cmd_t cmd;
  takf_pkg::takf_stat_t stat;
  logic [31:0] fa, cr;
  logic sat;

  takf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  takf_dp #(.FRAC_BITS(FRAC_BITS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .accel_sample(in_ch.accel_sample), .gyro_sample(in_ch.gyro_sample),
    .cmd(cmd), .stat(stat),
    .fused_angle(fa), .corrected_rate(cr), .saturated(sat)
  );

  assign out_ch.fused_angle = fa;
  assign out_ch.corrected_rate = cr;
  assign out_ch.saturated = sat;

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.fused_angle))
    else $error("result changed while stalled");

endmodule
